// ----- rtl/lifo_list_with_value_removal_core_macros.svh -----
// Assertion macros shared by the list core RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LIFO_LIST_WITH_VALUE_REMOVAL_CORE_MACROS_SVH
`define LIFO_LIST_WITH_VALUE_REMOVAL_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LVR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lvr check failed");

// Check that cons holds in the cycle after ante.
`define LVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lvr check failed");

`endif

// ----- rtl/lvr_pkg.sv -----
// Shared types and constants for the list core.
// No dependencies; imported by lvr_cell and the top level.
package lvr_pkg;

	localparam int CAPACITY      = 16;
	localparam int VALUE_BITS    = 32;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int FIELD_W       = 32;
	localparam int COUNT_FIELD_W = 5;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_PEEK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Shift commands broadcast to every cell
	typedef struct packed {
		logic push;   // take the entry from the head side
		logic pop;    // take the entry from the tail side
		logic rem;    // take from the tail side at and behind the first match
	} cell_ctrl_t;

endpackage

// ----- rtl/lvr_cell.sv -----
// One list position: holds an entry, compares it against the key, shifts with neighbors.
// Depends on lvr_pkg.
module lvr_cell
	import lvr_pkg::*;
(
	input  logic                         clk,
	input  cell_ctrl_t                   ctrl,
	input  logic signed [VALUE_BITS-1:0] left_in,
	input  logic signed [VALUE_BITS-1:0] right_in,
	input  logic signed [VALUE_BITS-1:0] key,
	input  logic                         in_use,
	input  logic                         hit_in,
	output logic                         hit_out,
	output logic signed [VALUE_BITS-1:0] entry
);

	logic signed [VALUE_BITS-1:0] entry_q;
	logic                         match;

	// Flag this position once any position from the head down to here matches
	assign match   = in_use && (entry_q == key);
	assign hit_out = hit_in || match;
	assign entry   = entry_q;

	// Shift toward the tail on push, toward the head on pop or behind a removal; else hold
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= left_in;
		end else if (ctrl.pop || (ctrl.rem && hit_out)) begin
			entry_q <= right_in;
		end
	end

endmodule

// ----- rtl/lifo_list_with_value_removal_core.sv -----
// List core: one item per cycle while not stalled; the result appears in the output register
// in the cycle after the item is accepted; the next item is taken while that result is taken.
// Throughput is one item per cycle without stalls, set by the cell row's compare and shift.
// Reset clears the entry count and the output valid flag; entries hold garbage until pushed.
// Depends on lvr_pkg, lvr_cell and lifo_list_with_value_removal_core_macros.svh.
`include "lifo_list_with_value_removal_core_macros.svh"

module lifo_list_with_value_removal_core
	import lvr_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      mode,
	input  logic signed [FIELD_W-1:0]       value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [FIELD_W-1:0]       head_value,
	output logic                            not_empty,
	output logic [COUNT_FIELD_W-1:0]        entry_count,
	output logic [1:0]                      status
);

	logic                         in_fire;
	mode_t                        op;
	logic signed [VALUE_BITS-1:0] key;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_d;
	status_t                      status_q;
	status_t                      status_d;
	logic                         out_valid_q;
	logic                         empty;
	logic                         full;
	logic                         found;
	cell_ctrl_t                   ctrl;
	logic [CAPACITY:0]            hit_chain;
	logic signed [VALUE_BITS-1:0] entry [CAPACITY];

	// Accept a new item whenever the output register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign op       = mode_t'(mode);
	assign key      = VALUE_BITS'($unsigned(value));

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = hit_chain[CAPACITY];

	// Broadcast shift commands to the cell row
	assign ctrl.push = in_fire && (op == MODE_PUSH) && !full;
	assign ctrl.pop  = in_fire && (op == MODE_POP) && !empty;
	assign ctrl.rem  = in_fire && (op == MODE_REMOVE) && found;

	assign hit_chain[0] = 1'b0;

	// Build the cell row, head at position zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(i);
		logic signed [VALUE_BITS-1:0] left_in;
		logic signed [VALUE_BITS-1:0] right_in;

		if (i == 0) begin : g_head
			assign left_in = key;
		end else begin : g_mid
			assign left_in = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_in = entry[i];
		end else begin : g_body
			assign right_in = entry[i+1];
		end

		lvr_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.left_in  (left_in),
			.right_in (right_in),
			.key      (key),
			.in_use   (POS < count_q),
			.hit_in   (hit_chain[i]),
			.hit_out  (hit_chain[i+1]),
			.entry    (entry[i])
		);
	end

	// Work out the new count and status
	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		unique case (op)
			MODE_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (found) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			MODE_PEEK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Hold count and result; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				status_q    <= status_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// State only moves with a new result, so the head cell reflects the pending result
	assign out_valid   = out_valid_q;
	assign not_empty   = !empty;
	assign head_value  = empty ? '0 : FIELD_W'(entry[0]);
	assign entry_count = COUNT_FIELD_W'(count_q);
	assign status      = status_q;

	`LVR_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`LVR_ASSERT_NEXT(a_push_grows, clk, arst_n, ctrl.push, count_q == $past(count_q) + CNT_W'(1))
	`LVR_ASSERT_NEXT(a_push_head, clk, arst_n, ctrl.push, entry[0] == $past(key))
	`LVR_ASSERT_NOW(a_empty_status, clk, arst_n, out_valid_q && (status_q == ST_EMPTY), empty)
	`LVR_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, ctrl.rem, count_q == $past(count_q) - CNT_W'(1))

endmodule

// ----- bench/tb_lifo_list_with_value_removal_core.sv -----
// Self-checking bench for the list core: a directed table, then random push, pop,
// remove and peek traffic under four handshake pacing phases, checked by a local predictor.
// Depends on lvr_pkg and lifo_list_with_value_removal_core.
`timescale 1ns / 100ps

module tb_lifo_list_with_value_removal_core;
	import lvr_pkg::*;

	localparam int DIR_ROWS       = 27;
	localparam int RAND_PER_PHASE = 190;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct packed {
		logic [FIELD_W-1:0]       head;
		logic                     ne;
		logic [COUNT_FIELD_W-1:0] cnt;
		status_t                  st;
	} list_result_t;

	typedef struct packed {
		mode_t              op;
		logic [FIELD_W-1:0] val;
		logic               typed;
		list_result_t       res;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [1:0]                      mode = MODE_PEEK;
	logic signed [FIELD_W-1:0]       value = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic signed [FIELD_W-1:0]       head_value;
	logic                            not_empty;
	logic [COUNT_FIELD_W-1:0]        entry_count;
	logic [1:0]                      status;

	// Shadow copy of the list, head at index 0
	logic [VALUE_BITS-1:0] shadow_entries [CAPACITY];
	int                    shadow_count = 0;
	list_result_t          pending_results [$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  error_count = 0;
	int  quiet_cycles = 0;

	// Directed rows; typed expectations only where the answer is obvious
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{MODE_PEEK,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 5'd0, ST_EMPTY}},
		'{MODE_POP,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 5'd0, ST_EMPTY}},
		'{MODE_REMOVE, 32'h0000_0007, 1'b1, '{32'h0000_0000, 1'b0, 5'd0, ST_EMPTY}},
		'{MODE_PUSH,   32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 5'd1, ST_OK}},
		'{MODE_PUSH,   32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 5'd2, ST_OK}},
		'{MODE_REMOVE, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 5'd2, ST_NOT_FOUND}},
		'{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 5'd1, ST_OK}},
		'{MODE_POP,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 5'd0, ST_OK}},
		'{MODE_PUSH,   32'h7FFF_FFFF, 1'b0, '0},
		'{MODE_PUSH,   32'h8000_0000, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_0000, 1'b0, '0},
		'{MODE_PUSH,   32'hFFFF_FFFF, 1'b0, '0},
		'{MODE_PUSH,   32'h5555_5555, 1'b0, '0},
		'{MODE_PUSH,   32'hAAAA_AAAA, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_0001, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_0005, 1'b0, '0},
		'{MODE_PUSH,   32'h0F0F_0F0F, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_0005, 1'b0, '0},
		'{MODE_PUSH,   32'h1234_5678, 1'b0, '0},
		'{MODE_PUSH,   32'hF0F0_F0F0, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_FFFF, 1'b0, '0},
		'{MODE_PUSH,   32'hFFFF_0000, 1'b0, '0},
		'{MODE_PUSH,   32'h8000_0001, 1'b0, '0},
		'{MODE_PUSH,   32'h0000_0005, 1'b0, '0},
		'{MODE_PUSH,   32'h7FFF_FFFF, 1'b1, '{32'h0000_0005, 1'b1, 5'd16, ST_FULL}},
		'{MODE_REMOVE, 32'h0000_0005, 1'b0, '0},
		'{MODE_REMOVE, 32'h8000_0000, 1'b0, '0}
	};

	lifo_list_with_value_removal_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.head_value  (head_value),
		.not_empty   (not_empty),
		.entry_count (entry_count),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Close the gap left by the entry at pos
	function automatic void drop_entry(input int pos);
		for (int i = pos; i + 1 < shadow_count; i++)
			shadow_entries[i] = shadow_entries[i + 1];
		shadow_count--;
	endfunction

	// Apply one operation to the shadow list and return the result it yields
	function automatic list_result_t apply_list_op(input mode_t op, input logic [FIELD_W-1:0] v);
		list_result_t r;
		status_t      st;
		int           hit;
		st = ST_OK;
		hit = -1;
		case (op)
			MODE_PUSH: begin
				if (shadow_count >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[0] = v;
					shadow_count++;
				end
			end
			MODE_POP: begin
				if (shadow_count == 0)
					st = ST_EMPTY;
				else
					drop_entry(0);
			end
			MODE_REMOVE: begin
				if (shadow_count == 0) begin
					st = ST_EMPTY;
				end else begin
					for (int i = 0; i < shadow_count && hit < 0; i++)
						if (shadow_entries[i] == v)
							hit = i;
					if (hit < 0)
						st = ST_NOT_FOUND;
					else
						drop_entry(hit);
				end
			end
			default: begin
				if (shadow_count == 0)
					st = ST_EMPTY;
			end
		endcase
		r.head = (shadow_count > 0) ? shadow_entries[0] : '0;
		r.ne   = (shadow_count > 0);
		r.cnt  = shadow_count[COUNT_FIELD_W-1:0];
		r.st   = st;
		return r;
	endfunction

	// Pick an operation; bias 0 fills the list, 1 drains it, 2 mixes
	function automatic mode_t pick_mode(input int bias);
		int r;
		int push_w;
		int pop_w;
		int rem_w;
		r = $urandom_range(99);
		case (bias)
			0:       begin push_w = 55; pop_w = 15; rem_w = 20; end
			1:       begin push_w = 15; pop_w = 35; rem_w = 40; end
			default: begin push_w = 35; pop_w = 25; rem_w = 25; end
		endcase
		if (r < push_w)
			return MODE_PUSH;
		if (r < push_w + pop_w)
			return MODE_POP;
		if (r < push_w + pop_w + rem_w)
			return MODE_REMOVE;
		return MODE_PEEK;
	endfunction

	// Favor a few values so duplicates appear; removes mostly target live entries
	function automatic logic [FIELD_W-1:0] pick_value(input mode_t op);
		int r;
		r = $urandom_range(99);
		if (op == MODE_REMOVE && shadow_count > 0 && r < 65)
			return shadow_entries[$urandom_range(shadow_count - 1)];
		if (r < 80) begin
			case ($urandom_range(5))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'hFFFF_FFFF;
				3: return 32'h0000_0000;
				default: return FIELD_W'($urandom_range(7));
			endcase
		end
		return $urandom();
	endfunction

	// Offer one item after a random gap; log its expected result on acceptance
	task automatic send_item(input mode_t op, input logic [FIELD_W-1:0] v,
			input logic typed, input list_result_t typed_res);
		list_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = apply_list_op(op, v);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// Stall the result side and compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		list_result_t e;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected: head %h count %0d status %0d",
						$time, head_value, entry_count, status);
					error_count++;
				end else begin
					e = pending_results.pop_front();
					if (head_value !== e.head) begin
						$display("%0t: head_value expected %h actual %h", $time, e.head, head_value);
						error_count++;
					end
					if (not_empty !== e.ne) begin
						$display("%0t: not_empty expected %b actual %b", $time, e.ne, not_empty);
						error_count++;
					end
					if (entry_count !== e.cnt) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, e.cnt, entry_count);
						error_count++;
					end
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						error_count++;
					end
				end
			end
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		mode_t        op;
		logic [31:0]  v;
		int           bias;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		for (int k = 0; k < DIR_ROWS; k++)
			send_item(dir_tab[k].op, dir_tab[k].val, dir_tab[k].typed, dir_tab[k].res);

		// Random traffic, one pacing setting per phase
		bias = 2;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				if (k % 40 == 0)
					bias = $urandom_range(2);
				op = pick_mode(bias);
				v  = pick_value(op);
				send_item(op, v, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
